### sv/arc_pkg.sv
package arc_pkg;

   // Default table depth
   localparam int TABLE_ENTRIES_DEF = 128;

   // Field widths
   localparam int CMD_W     = 2;
   localparam int IP_W      = 32;
   localparam int MAC_W     = 48;
   localparam int STAMP_W   = 32;
   localparam int STATUS_W  = 3;
   localparam int SLOT_W    = 7;
   localparam int TIMEOUT_W = 16;

   // Reset value of the timeout register
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd15;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] STAT_HIT      = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_MISS     = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_INSERTED = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_TICK     = 3'd4;

   typedef logic [SLOT_W-1:0] slot_type;

   // Request transaction
   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [IP_W-1:0]  ip_address;
      logic [MAC_W-1:0] mac_address;
   } req_type;

   // Response transaction
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [MAC_W-1:0]    mac_out;
      slot_type            slot;
   } rsp_type;

   // One table entry as stored in memory
   typedef struct packed {
      logic               valid;
      logic [IP_W-1:0]    ip;
      logic [MAC_W-1:0]   mac;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

endpackage

### sv/arc_table.sv
module arc_table #(
   parameter int TABLE_ENTRIES = arc_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] wr_addr,
   input  arc_pkg::entry_type           wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(TABLE_ENTRIES)-1:0] rd_addr,
   output arc_pkg::entry_type           rd_data
);

   arc_pkg::entry_type mem_ff [TABLE_ENTRIES];
   arc_pkg::entry_type rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/arc_scan.sv
module arc_scan #(
   parameter int TABLE_ENTRIES = arc_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  arc_pkg::req_type                    req_data,
   input  logic [arc_pkg::TIMEOUT_W-1:0]       timeout,
   output logic                                res_valid,
   input  logic                                res_take,
   output arc_pkg::rsp_type                    res_data,
   output logic                                wr_en,
   output logic [$clog2(TABLE_ENTRIES)-1:0]    wr_addr,
   output arc_pkg::entry_type                  wr_data,
   output logic                                rd_en,
   output logic [$clog2(TABLE_ENTRIES)-1:0]    rd_addr,
   input  arc_pkg::entry_type                  rd_data
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] LastIdx = IDX_W'(TABLE_ENTRIES - 1);

   typedef enum logic [3:0] {
      S_CLEAR = 4'b0001,
      S_IDLE  = 4'b0010,
      S_SCAN  = 4'b0100,
      S_DONE  = 4'b1000
   } state_type;

   state_type                          state_ff, state_in;
   logic [IDX_W-1:0]                   addr_ff, addr_in;
   logic                               rd_done_ff, rd_done_in;
   logic                               chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]                   chk_idx_ff, chk_idx_in;
   logic [arc_pkg::CMD_W-1:0]          cmd_ff, cmd_in;
   logic [arc_pkg::IP_W-1:0]           ip_ff, ip_in;
   logic [arc_pkg::MAC_W-1:0]          mac_ff, mac_in;
   logic [arc_pkg::STAMP_W-1:0]        seconds_ff, seconds_in;
   arc_pkg::rsp_type                   res_ff, res_in;

   logic                               accept;
   logic [arc_pkg::STAMP_W-1:0]        age;
   logic                               ip_match;
   logic                               expired;
   logic                               chk_last;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res_data  = res_ff;

   // Shared compare unit: one entry per cycle
   assign age      = seconds_ff - rd_data.stamp;
   assign ip_match = rd_data.valid && (rd_data.ip == ip_ff);
   assign expired  = rd_data.valid &&
                     (age > {{(arc_pkg::STAMP_W - arc_pkg::TIMEOUT_W){1'b0}}, timeout});
   assign chk_last = (chk_idx_ff == LastIdx);

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      addr_in    = addr_ff;
      rd_done_in = rd_done_ff;
      chk_vld_in = 1'b0;
      chk_idx_in = addr_ff;
      cmd_in     = cmd_ff;
      ip_in      = ip_ff;
      mac_in     = mac_ff;
      seconds_in = seconds_ff;
      res_in     = res_ff;
      rd_en      = 1'b0;
      rd_addr    = addr_ff;
      wr_en      = 1'b0;
      wr_addr    = chk_idx_ff;
      wr_data    = rd_data;

      unique case (state_ff)
         S_CLEAR: begin
            // Post-reset pass that marks every slot invalid
            wr_en   = 1'b1;
            wr_addr = addr_ff;
            wr_data = '0;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == LastIdx) begin
               addr_in  = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd_in     = req_data.command;
               ip_in      = req_data.ip_address;
               mac_in     = req_data.mac_address;
               addr_in    = '0;
               rd_done_in = 1'b0;
               state_in   = S_SCAN;
               res_in     = '0;
               unique case (req_data.command)
                  arc_pkg::CMD_LOOKUP: res_in.status = arc_pkg::STAT_MISS;
                  arc_pkg::CMD_INSERT: res_in.status = arc_pkg::STAT_FULL;
                  arc_pkg::CMD_TICK: begin
                     res_in.status = arc_pkg::STAT_TICK;
                     seconds_in    = seconds_ff + 1'b1;
                  end
                  default: begin
                     res_in.status = arc_pkg::STAT_MISS;
                     state_in      = S_DONE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // Issue the next sequential read
            rd_en      = !rd_done_ff;
            chk_vld_in = !rd_done_ff;
            if (!rd_done_ff) begin
               addr_in = addr_ff + 1'b1;
               if (addr_ff == LastIdx) begin
                  rd_done_in = 1'b1;
               end
            end
            // Check the entry read in the previous cycle
            if (chk_vld_ff) begin
               unique case (cmd_ff)
                  arc_pkg::CMD_LOOKUP: begin
                     if (ip_match) begin
                        res_in.status  = arc_pkg::STAT_HIT;
                        res_in.mac_out = rd_data.mac;
                        res_in.slot    = arc_pkg::slot_type'(chk_idx_ff);
                     end
                     if (chk_last) begin
                        state_in = S_DONE;
                     end
                  end
                  arc_pkg::CMD_INSERT: begin
                     if (!rd_data.valid) begin
                        wr_en         = 1'b1;
                        wr_data.valid = 1'b1;
                        wr_data.ip    = ip_ff;
                        wr_data.mac   = mac_ff;
                        wr_data.stamp = seconds_ff;
                        res_in.status = arc_pkg::STAT_INSERTED;
                        res_in.slot   = arc_pkg::slot_type'(chk_idx_ff);
                        state_in      = S_DONE;
                     end else if (chk_last) begin
                        state_in = S_DONE;
                     end
                  end
                  default: begin
                     // Aging sweep
                     if (expired) begin
                        wr_en         = 1'b1;
                        wr_data.valid = 1'b0;
                     end
                     if (chk_last) begin
                        state_in = S_DONE;
                     end
                  end
               endcase
            end
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
            addr_in  = '0;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         addr_ff    <= '0;
         rd_done_ff <= 1'b0;
         chk_vld_ff <= 1'b0;
         seconds_ff <= '0;
      end else begin
         state_ff   <= state_in;
         addr_ff    <= addr_in;
         rd_done_ff <= rd_done_in;
         chk_vld_ff <= chk_vld_in;
         seconds_ff <= seconds_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      chk_idx_ff <= chk_idx_in;
      cmd_ff     <= cmd_in;
      ip_ff      <= ip_in;
      mac_ff     <= mac_in;
      res_ff     <= res_in;
   end

endmodule

### sv/address_resolution_cache.sv
// Address resolution cache: a table of TABLE_ENTRIES slots mapping IPv4 to MAC
// addresses. After reset the block clears every slot of the table and holds
// req_ready low meanwhile; csr writes are taken at any time. Commands
// run one at a time through a single compare unit that reads one slot per
// cycle from the table memory: a lookup or a tick scans every slot, an insert
// scans up to the first free slot (every slot when the table is full), and an
// unused command code answers a miss without a scan. A lookup returns the
// highest-numbered matching slot; an insert does not check for duplicates.
// The finished response sits in an output register, so it may wait on
// rsp_ready while the next request is taken.
module address_resolution_cache #(
   parameter int TABLE_ENTRIES = arc_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  arc_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output arc_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [arc_pkg::TIMEOUT_W-1:0]  csr_data
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);

   logic [arc_pkg::TIMEOUT_W-1:0] timeout_ff;
   logic                          rsp_valid_ff;
   arc_pkg::rsp_type              rsp_data_ff;

   logic                          res_valid;
   logic                          res_take;
   arc_pkg::rsp_type              res_data;
   logic                          wr_en;
   logic [IDX_W-1:0]              wr_addr;
   arc_pkg::entry_type            wr_data;
   logic                          rd_en;
   logic [IDX_W-1:0]              rd_addr;
   arc_pkg::entry_type            rd_data;

   arc_scan #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .timeout   (timeout_ff),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res_data  (res_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   arc_table #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Timeout register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= arc_pkg::TIMEOUT_RESET;
      end else if (csr_valid) begin
         timeout_ff <= csr_data;
      end
   end

   // Output register
   assign res_take = res_valid && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### sv/arc_checker.sv
module arc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input arc_pkg::rsp_type              rsp_data
);

   // A stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // One transaction at a time: busy right after acceptance
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // Only a hit carries a MAC
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status != arc_pkg::STAT_HIT) |-> rsp_data.mac_out == '0)
      else $error("MAC on a non-hit response");

   // Miss, full and tick carry no slot
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == arc_pkg::STAT_MISS ||
                    rsp_data.status == arc_pkg::STAT_FULL ||
                    rsp_data.status == arc_pkg::STAT_TICK) |-> rsp_data.slot == '0)
      else $error("slot on a response that has none");

endmodule

bind address_resolution_cache arc_checker u_arc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### tb/tb_address_resolution_cache.sv
`timescale 1ns / 100ps

module tb_address_resolution_cache;

   localparam int TABLE_ENTRIES = arc_pkg::TABLE_ENTRIES_DEF;
   localparam int RANDOM_ITEMS  = 1400;
   localparam int CYCLE_LIMIT   = 1_500_000;
   localparam int PRINT_LIMIT   = 40;

   typedef logic [arc_pkg::IP_W-1:0]      ip_type;
   typedef logic [arc_pkg::MAC_W-1:0]     mac_type;
   typedef logic [arc_pkg::STAMP_W-1:0]   stamp_type;
   typedef logic [arc_pkg::TIMEOUT_W-1:0] timeout_type;
   typedef logic [arc_pkg::CMD_W-1:0]     cmd_type;

   // command code the block does not define; answered as a miss
   localparam cmd_type CMD_UNUSED = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   arc_pkg::req_type     req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   arc_pkg::rsp_type     rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   timeout_type          csr_data = '0;

   // shadow copy of the table and the aging state
   logic                 cache_valid [TABLE_ENTRIES];
   ip_type               cache_ip    [TABLE_ENTRIES];
   mac_type              cache_mac   [TABLE_ENTRIES];
   stamp_type            cache_stamp [TABLE_ENTRIES];
   stamp_type            tick_seconds = '0;
   timeout_type          timeout_now = arc_pkg::TIMEOUT_RESET;

   arc_pkg::req_type req_backlog[$];
   arc_pkg::rsp_type pending_rsp[$];

   int gap_pct      = 0;
   int req_gap      = 0;
   int rsp_stall    = 0;
   int random_items = 0;
   int error_count  = 0;
   int cycle_count  = 0;

   always #5 clock = ~clock;

   address_resolution_cache #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         cache_valid[i] = 1'b0;
         cache_ip[i]    = '0;
         cache_mac[i]   = '0;
         cache_stamp[i] = '0;
      end
   end

   // applies one command to the shadow table and returns the response it owes
   function automatic arc_pkg::rsp_type resolve_command(input arc_pkg::req_type r);
      arc_pkg::rsp_type   res;
      int                 hit_at;
      int                 free_at;
      stamp_type          age;
      res        = '0;
      res.status = arc_pkg::STAT_MISS;
      case (r.command)
         arc_pkg::CMD_LOOKUP: begin
            hit_at = -1;
            for (int i = 0; i < TABLE_ENTRIES; i++)
               if (cache_valid[i] && cache_ip[i] == r.ip_address) hit_at = i;
            if (hit_at >= 0) begin
               res.status  = arc_pkg::STAT_HIT;
               res.mac_out = cache_mac[hit_at];
               res.slot    = arc_pkg::slot_type'(hit_at);
            end
         end
         arc_pkg::CMD_INSERT: begin
            free_at = -1;
            for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
               if (!cache_valid[i]) free_at = i;
            if (free_at < 0) begin
               res.status = arc_pkg::STAT_FULL;
            end else begin
               cache_valid[free_at] = 1'b1;
               cache_ip[free_at]    = r.ip_address;
               cache_mac[free_at]   = r.mac_address;
               cache_stamp[free_at] = tick_seconds;
               res.status           = arc_pkg::STAT_INSERTED;
               res.slot             = arc_pkg::slot_type'(free_at);
            end
         end
         arc_pkg::CMD_TICK: begin
            tick_seconds = tick_seconds + 1'b1;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               age = tick_seconds - cache_stamp[i];
               if (cache_valid[i] && age > stamp_type'(timeout_now)) cache_valid[i] = 1'b0;
            end
            res.status = arc_pkg::STAT_TICK;
         end
         default: res.status = arc_pkg::STAT_MISS;
      endcase
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (error_count < PRINT_LIMIT)
         $display("%0t mismatch in %s: got %0h, expected %0h", $time, what, got, want);
      error_count++;
   endtask

   function automatic arc_pkg::req_type make_req(input cmd_type cmd,
                                                 input ip_type ip,
                                                 input mac_type mac);
      arc_pkg::req_type r;
      r.command     = cmd;
      r.ip_address  = ip;
      r.mac_address = mac;
      return r;
   endfunction

   function automatic mac_type random_mac();
      return {16'($urandom), 32'($urandom)};
   endfunction

   // request driver: predicts on acceptance, then offers the next transaction or a gap
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) pending_rsp.push_back(resolve_command(req_data));
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (req_backlog.size() != 0 && gap_pct != 0 &&
                      $urandom_range(99) < gap_pct) begin
            req_gap = $urandom_range(11);
            req_valid <= 1'b0;
         end else if (req_backlog.size() != 0) begin
            req_valid <= 1'b1;
            req_data  <= req_backlog.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response monitor: checks each transaction against the oldest prediction
   always @(posedge clock) begin
      arc_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               report_mismatch("unexpected response", 64'(rsp_data), 64'd0);
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 64'(rsp_data.status), 64'(want.status));
               if (rsp_data.mac_out !== want.mac_out)
                  report_mismatch("mac_out", 64'(rsp_data.mac_out), 64'(want.mac_out));
               if (rsp_data.slot !== want.slot)
                  report_mismatch("slot", 64'(rsp_data.slot), 64'(want.slot));
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            rsp_stall = $urandom_range(11);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // block is idle once nothing is queued, offered or owed
   task automatic wait_drained();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || pending_rsp.size() != 0);
   endtask

   task automatic write_timeout(input timeout_type value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid   <= 1'b0;
      timeout_now = value;
      @(negedge clock);
   endtask

   // random traffic around a small pool of addresses so lookups hit and inserts repeat
   task automatic queue_mix(input int count, input int insert_pct, input int tick_pct);
      ip_type            pool[$];
      ip_type            ip;
      cmd_type           cmd;
      int                pick;
      int                pool_size;
      pool_size = $urandom_range(3, 40);
      for (int i = 0; i < pool_size; i++) pool.push_back(ip_type'($urandom));
      if ($urandom_range(1)) pool.push_back('0);
      if ($urandom_range(1)) pool.push_back('1);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(9) == 0) ip = ip_type'($urandom);
         else ip = pool[$urandom_range(pool.size() - 1)];
         pick = $urandom_range(99);
         if (pick < insert_pct) cmd = arc_pkg::CMD_INSERT;
         else if (pick < insert_pct + tick_pct) cmd = arc_pkg::CMD_TICK;
         else if (pick < insert_pct + tick_pct + 3) cmd = CMD_UNUSED;
         else cmd = arc_pkg::CMD_LOOKUP;
         req_backlog.push_back(make_req(cmd, ip, random_mac()));
         if (cmd != CMD_UNUSED) random_items++;
      end
   endtask

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      timeout_type          timeout_pick;
      int                   phase;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, address extremes, duplicates, unused code, default timeout
      req_backlog.push_back(make_req(arc_pkg::CMD_LOOKUP, '0, '0));
      req_backlog.push_back(make_req(arc_pkg::CMD_INSERT, '0, '0));
      req_backlog.push_back(make_req(arc_pkg::CMD_INSERT, '1, '1));
      req_backlog.push_back(make_req(arc_pkg::CMD_LOOKUP, '1, '0));
      req_backlog.push_back(make_req(arc_pkg::CMD_LOOKUP, '0, '1));
      req_backlog.push_back(make_req(arc_pkg::CMD_INSERT, '1, 48'h5A5A_A5A5_0F0F));
      req_backlog.push_back(make_req(arc_pkg::CMD_LOOKUP, '1, '0));
      req_backlog.push_back(make_req(CMD_UNUSED, '1, '1));
      req_backlog.push_back(make_req(CMD_UNUSED, '0, '0));
      req_backlog.push_back(make_req(arc_pkg::CMD_TICK, '1, '1));
      req_backlog.push_back(make_req(arc_pkg::CMD_LOOKUP, 32'h0000_0001, '0));
      wait_drained();

      // zero timeout: one tick ages out everything
      write_timeout('0);
      req_backlog.push_back(make_req(arc_pkg::CMD_INSERT, 32'hC0A8_0001, random_mac()));
      req_backlog.push_back(make_req(arc_pkg::CMD_LOOKUP, 32'hC0A8_0001, '0));
      req_backlog.push_back(make_req(arc_pkg::CMD_TICK, '0, '0));
      req_backlog.push_back(make_req(arc_pkg::CMD_LOOKUP, 32'hC0A8_0001, '0));
      req_backlog.push_back(make_req(arc_pkg::CMD_LOOKUP, '0, '0));
      req_backlog.push_back(make_req(arc_pkg::CMD_INSERT, '0, random_mac()));
      wait_drained();

      // random phases, each with its own timeout and gap density
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         case (phase % 8)
            0: timeout_pick = '1;
            1: timeout_pick = 16'd2;
            2: timeout_pick = '0;
            3: timeout_pick = 16'd1;
            4: timeout_pick = arc_pkg::TIMEOUT_RESET;
            5: timeout_pick = timeout_type'($urandom_range(3, 40));
            6: timeout_pick = timeout_type'($urandom);
            default: timeout_pick = '1;
         endcase
         if (random_items >= RANDOM_ITEMS - 200) gap_pct = 0;
         else case ($urandom_range(2))
            0: gap_pct = 0;
            1: gap_pct = 10;
            default: gap_pct = 35;
         endcase
         write_timeout(timeout_pick);
         // longest timeout, mostly inserts and no ticks: the table fills and overflows
         if (phase % 8 == 0) queue_mix(170, 85, 0);
         else queue_mix($urandom_range(60, 160), 35, 15);
         wait_drained();
         phase++;
      end

      repeat (TABLE_ENTRIES + 10) @(posedge clock);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### files.f
sv/arc_pkg.sv
sv/arc_table.sv
sv/arc_scan.sv
sv/address_resolution_cache.sv
sv/arc_checker.sv
tb/tb_address_resolution_cache.sv
